// ===== rtl/lcpe_pkg.sv =====
package lcpe_pkg;

    localparam int TIMING_WIDTH = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int BYTE_W       = 8;
    localparam int BITS_W       = 4;

    typedef logic [TIMING_WIDTH-1:0] t_timing;
    typedef logic [CFG_IDX_W-1:0]    t_cfg_idx;
    typedef logic [BITS_W-1:0]       t_bits;

    localparam t_cfg_idx CFG_SLOW_MODE      = 3'd0;
    localparam t_cfg_idx CFG_FAST_ZERO_HIGH = 3'd1;
    localparam t_cfg_idx CFG_FAST_ONE_HIGH  = 3'd2;
    localparam t_cfg_idx CFG_FAST_PERIOD    = 3'd3;
    localparam t_cfg_idx CFG_SLOW_ZERO_HIGH = 3'd4;
    localparam t_cfg_idx CFG_SLOW_ONE_HIGH  = 3'd5;
    localparam t_cfg_idx CFG_SLOW_PERIOD    = 3'd6;

    localparam t_timing RST_FAST_ZERO_HIGH = t_timing'(40);
    localparam t_timing RST_FAST_ONE_HIGH  = t_timing'(80);
    localparam t_timing RST_FAST_PERIOD    = t_timing'(125);
    localparam t_timing RST_SLOW_ZERO_HIGH = t_timing'(50);
    localparam t_timing RST_SLOW_ONE_HIGH  = t_timing'(120);
    localparam t_timing RST_SLOW_PERIOD    = t_timing'(250);

    localparam t_bits BITS_PER_BYTE = t_bits'(BYTE_W);

endpackage

// ===== rtl/led_chain_pulse_encoder.sv =====
// Single-wire LED chain pulse encoder.
// Input channel (i_valid / o_stall): each accepted item is one tick of the
// pulse timer and may offer a data byte with a last-byte mark.
// Output channel (o_valid / i_stall): exactly one result item per input item,
// carrying the line level of that tick, whether the offered byte was taken,
// and a frame-done pulse at the end of the final bit period of a last byte.
// Configuration channel (i_cfg_valid / o_cfg_ready): always ready; index 0
// selects the slow timing set, indexes 1..6 hold the high times and periods.
// The result of an item is registered and presented in the cycle after it is accepted.
// Throughput: one item per cycle while the receiver does not stall, set by the single result register.
// A stalled result holds in the result register; o_stall rises only while a
// result is held and the receiver stalls, so a new item enters in the same
// cycle the held one is taken.
// Reset (synchronous, active low) empties the holding register, idles the bit
// engine, drops o_valid and loads the default timing values.
module led_chain_pulse_encoder (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_byte_offered,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_byte,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_line_level,
    output logic                   o_byte_taken,
    output logic                   o_frame_done,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [lcpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lcpe_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lcpe_pkg::*;

    logic    r_slow_mode;
    t_timing r_fast_zero_high, r_fast_one_high, r_fast_period;
    t_timing r_slow_zero_high, r_slow_one_high, r_slow_period;

    logic [BYTE_W-1:0] r_shift_byte, n_shift_byte;
    t_bits             r_bits_left, n_bits_left;
    t_timing           r_tick_count, n_tick_count;
    t_timing           r_high_time, n_high_time;
    logic [BYTE_W-1:0] r_hold_byte, n_hold_byte;
    logic              r_hold_full, n_hold_full;
    logic              r_hold_last, n_hold_last;
    logic              r_current_last, n_current_last;
    logic              r_active, n_active;
    logic              r_tail_wait, n_tail_wait;

    logic r_out_valid, r_line_level, r_byte_taken, r_frame_done;
    logic n_line_level, n_byte_taken, n_frame_done;

    logic    in_acc;
    logic    cfg_we;
    t_timing cfg_val;
    t_timing period;
    t_timing tick_inc;
    t_bits   bits_dec;
    logic    bit_end;

    assign o_stall     = r_out_valid & i_stall;
    assign in_acc      = i_valid & ~o_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;
    assign cfg_val     = t_timing'(i_cfg_data);

    assign o_valid      = r_out_valid;
    assign o_line_level = r_line_level;
    assign o_byte_taken = r_byte_taken;
    assign o_frame_done = r_frame_done;

    assign period   = r_slow_mode ? r_slow_period : r_fast_period;
    assign tick_inc = r_tick_count + t_timing'(1);
    assign bits_dec = r_bits_left - t_bits'(1);
    assign bit_end  = (tick_inc >= period) || (tick_inc == '0);

    function automatic t_timing pick_high(input logic slow, input logic one,
                                          input t_timing fz, input t_timing fo,
                                          input t_timing sz, input t_timing so);
        if (slow) begin
            return one ? so : sz;
        end
        return one ? fo : fz;
    endfunction

    always_comb begin
        n_shift_byte   = r_shift_byte;
        n_bits_left    = r_bits_left;
        n_tick_count   = r_tick_count;
        n_high_time    = r_high_time;
        n_hold_byte    = r_hold_byte;
        n_hold_full    = r_hold_full;
        n_hold_last    = r_hold_last;
        n_current_last = r_current_last;
        n_active       = r_active;
        n_tail_wait    = r_tail_wait;

        n_line_level = r_active && (r_tick_count < r_high_time);
        n_byte_taken = i_byte_offered & ~r_hold_full;
        n_frame_done = 1'b0;

        if (r_active) begin
            n_tick_count = tick_inc;
            if (bit_end) begin
                if (r_tail_wait) begin
                    n_frame_done = 1'b1;
                    n_tail_wait  = 1'b0;
                    n_active     = 1'b0;
                    n_bits_left  = '0;
                end else begin
                    n_shift_byte = {r_shift_byte[BYTE_W-2:0], 1'b0};
                    if (bits_dec == '0 || bits_dec > BITS_PER_BYTE) begin
                        n_bits_left = '0;
                        n_active    = 1'b0;
                    end else begin
                        n_bits_left  = bits_dec;
                        n_high_time  = pick_high(r_slow_mode, r_shift_byte[BYTE_W-2],
                                                 r_fast_zero_high, r_fast_one_high,
                                                 r_slow_zero_high, r_slow_one_high);
                        n_tick_count = '0;
                        n_tail_wait  = r_current_last && (bits_dec == t_bits'(1));
                    end
                end
            end
        end

        if (!n_active && r_hold_full) begin
            n_shift_byte   = r_hold_byte;
            n_current_last = r_hold_last;
            n_bits_left    = BITS_PER_BYTE;
            n_hold_full    = 1'b0;
            n_active       = 1'b1;
            n_high_time    = pick_high(r_slow_mode, r_hold_byte[BYTE_W-1],
                                       r_fast_zero_high, r_fast_one_high,
                                       r_slow_zero_high, r_slow_one_high);
            n_tick_count   = '0;
            n_tail_wait    = 1'b0;
        end

        if (n_byte_taken) begin
            n_hold_byte = i_data_byte;
            n_hold_last = i_last_byte;
            n_hold_full = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_mode      <= 1'b0;
            r_fast_zero_high <= RST_FAST_ZERO_HIGH;
            r_fast_one_high  <= RST_FAST_ONE_HIGH;
            r_fast_period    <= RST_FAST_PERIOD;
            r_slow_zero_high <= RST_SLOW_ZERO_HIGH;
            r_slow_one_high  <= RST_SLOW_ONE_HIGH;
            r_slow_period    <= RST_SLOW_PERIOD;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_SLOW_MODE:      r_slow_mode      <= i_cfg_data[0];
                CFG_FAST_ZERO_HIGH: r_fast_zero_high <= cfg_val;
                CFG_FAST_ONE_HIGH:  r_fast_one_high  <= cfg_val;
                CFG_FAST_PERIOD:    r_fast_period    <= cfg_val;
                CFG_SLOW_ZERO_HIGH: r_slow_zero_high <= cfg_val;
                CFG_SLOW_ONE_HIGH:  r_slow_one_high  <= cfg_val;
                CFG_SLOW_PERIOD:    r_slow_period    <= cfg_val;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_byte   <= '0;
            r_bits_left    <= '0;
            r_tick_count   <= '0;
            r_high_time    <= '0;
            r_hold_byte    <= '0;
            r_hold_full    <= 1'b0;
            r_hold_last    <= 1'b0;
            r_current_last <= 1'b0;
            r_active       <= 1'b0;
            r_tail_wait    <= 1'b0;
        end else if (in_acc) begin
            r_shift_byte   <= n_shift_byte;
            r_bits_left    <= n_bits_left;
            r_tick_count   <= n_tick_count;
            r_high_time    <= n_high_time;
            r_hold_byte    <= n_hold_byte;
            r_hold_full    <= n_hold_full;
            r_hold_last    <= n_hold_last;
            r_current_last <= n_current_last;
            r_active       <= n_active;
            r_tail_wait    <= n_tail_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_line_level <= n_line_level;
            r_byte_taken <= n_byte_taken;
            r_frame_done <= n_frame_done;
        end
    end

endmodule

// ===== sim/led_chain_pulse_encoder_test.sv =====
module led_chain_pulse_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcpe_pkg::*;

    localparam int LATENCY_PAD = 4;
    localparam int IDLE_PCT    = 13;
    localparam int HOLD_CYCLES = 80;

    class line_tick_tracker;
        typedef struct packed {
            logic line;
            logic taken;
            logic done;
        } t_tick_out;

        t_timing    regs [0:6];
        logic [7:0] shift_byte;
        logic [7:0] hold_byte;
        t_bits      bits_left;
        t_timing    tick_count;
        t_timing    high_time;
        logic       hold_full;
        logic       hold_last;
        logic       cur_last;
        logic       active;
        logic       tail_wait;
        t_tick_out  expected_ticks [$];
        int         mismatches;

        function new();
            regs[CFG_SLOW_MODE]      = '0;
            regs[CFG_FAST_ZERO_HIGH] = RST_FAST_ZERO_HIGH;
            regs[CFG_FAST_ONE_HIGH]  = RST_FAST_ONE_HIGH;
            regs[CFG_FAST_PERIOD]    = RST_FAST_PERIOD;
            regs[CFG_SLOW_ZERO_HIGH] = RST_SLOW_ZERO_HIGH;
            regs[CFG_SLOW_ONE_HIGH]  = RST_SLOW_ONE_HIGH;
            regs[CFG_SLOW_PERIOD]    = RST_SLOW_PERIOD;
            shift_byte = '0;
            hold_byte  = '0;
            bits_left  = '0;
            tick_count = '0;
            high_time  = '0;
            hold_full  = 1'b0;
            hold_last  = 1'b0;
            cur_last   = 1'b0;
            active     = 1'b0;
            tail_wait  = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_SLOW_MODE) begin
                regs[idx] = t_timing'(value[0]);
            end else if (idx <= CFG_SLOW_PERIOD) begin
                regs[idx] = t_timing'(value);
            end
        endfunction

        function void load_bit();
            logic one;
            one = shift_byte[7];
            if (regs[CFG_SLOW_MODE][0]) begin
                high_time = one ? regs[CFG_SLOW_ONE_HIGH] : regs[CFG_SLOW_ZERO_HIGH];
            end else begin
                high_time = one ? regs[CFG_FAST_ONE_HIGH] : regs[CFG_FAST_ZERO_HIGH];
            end
            tick_count = '0;
            tail_wait  = cur_last && bits_left == t_bits'(1);
        endfunction

        function void note_tick(logic offered, logic [7:0] data, logic last);
            t_tick_out res;
            logic      was_full;
            t_timing   period;
            res.line  = active && tick_count < high_time;
            was_full  = hold_full;
            res.taken = offered && !was_full;
            res.done  = 1'b0;
            if (active) begin
                tick_count = tick_count + t_timing'(1);
                period = regs[CFG_SLOW_MODE][0] ? regs[CFG_SLOW_PERIOD] : regs[CFG_FAST_PERIOD];
                if (tick_count >= period || tick_count == '0) begin
                    if (tail_wait) begin
                        res.done  = 1'b1;
                        tail_wait = 1'b0;
                        active    = 1'b0;
                        bits_left = '0;
                    end else begin
                        bits_left  = bits_left - t_bits'(1);
                        shift_byte = shift_byte << 1;
                        if (bits_left == '0 || bits_left > BITS_PER_BYTE) begin
                            bits_left = '0;
                            active    = 1'b0;
                        end else begin
                            load_bit();
                        end
                    end
                end
            end
            if (!active && was_full) begin
                shift_byte = hold_byte;
                cur_last   = hold_last;
                bits_left  = BITS_PER_BYTE;
                hold_full  = 1'b0;
                active     = 1'b1;
                load_bit();
            end
            if (res.taken) begin
                hold_byte = data;
                hold_last = last;
                hold_full = 1'b1;
            end
            expected_ticks.push_back(res);
        endfunction

        function void check_tick(logic line, logic taken, logic done);
            t_tick_out want;
            if (expected_ticks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result item: line %0b taken %0b done %0b",
                             line, taken, done);
                end
                return;
            end
            want = expected_ticks.pop_front();
            if (line !== want.line || taken !== want.taken || done !== want.done) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"mismatch at %0t: expected line %0b taken %0b done %0b, ",
                              "got %0b %0b %0b"},
                             $realtime, want.line, want.taken, want.done, line, taken, done);
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_byte_offered;
    logic [7:0]            i_data_byte;
    logic                  i_last_byte;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_line_level;
    logic                  o_byte_taken;
    logic                  o_frame_done;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic calm;
    logic hold_req;

    line_tick_tracker tracker = new();

    led_chain_pulse_encoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_byte_offered (i_byte_offered),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_line_level   (o_line_level),
        .o_byte_taken   (o_byte_taken),
        .o_frame_done   (o_frame_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // drain results, with random stalls and one long hold-off
    initial begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && !i_stall) begin
                tracker.check_tick(o_line_level, o_byte_taken, o_frame_done);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_req && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= !calm && $urandom_range(99) < IDLE_PCT;
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.set_reg(idx, value);
    endtask

    task automatic program_timing(logic mode, logic [15:0] fz, logic [15:0] fo,
                                  logic [15:0] fp, logic [15:0] sz, logic [15:0] so,
                                  logic [15:0] sp);
        write_reg(CFG_SLOW_MODE, {15'd0, mode});
        write_reg(CFG_FAST_ZERO_HIGH, fz);
        write_reg(CFG_FAST_ONE_HIGH, fo);
        write_reg(CFG_FAST_PERIOD, fp);
        write_reg(CFG_SLOW_ZERO_HIGH, sz);
        write_reg(CFG_SLOW_ONE_HIGH, so);
        write_reg(CFG_SLOW_PERIOD, sp);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_item(logic offered, logic [7:0] data, logic last);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_byte_offered <= offered;
        i_data_byte    <= data;
        i_last_byte    <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.note_tick(offered, data, last);
    endtask

    task automatic send_random(int count);
        logic [7:0] data;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(7))
                0:       data = 8'h00;
                1:       data = 8'hFF;
                default: data = 8'($urandom_range(255));
            endcase
            send_item($urandom_range(99) < 80, data, $urandom_range(5) == 0);
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (tracker.expected_ticks.size() != 0) @(posedge i_clk);
    endtask

    task automatic end_phase();
        settle();
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    initial begin
        logic [9:0] directed [25];
        directed = '{
            {1'b1, 8'hFF, 1'b0}, {1'b1, 8'h00, 1'b1}, {1'b0, 8'h5A, 1'b1},
            {1'b0, 8'hFF, 1'b0}, {1'b1, 8'h00, 1'b1}, {1'b1, 8'h00, 1'b1},
            {1'b1, 8'h00, 1'b1}, {1'b1, 8'h00, 1'b1}, {1'b1, 8'h00, 1'b1},
            {1'b1, 8'h00, 1'b1}, {1'b1, 8'h80, 1'b1}, {1'b1, 8'h80, 1'b1},
            {1'b1, 8'h80, 1'b1}, {1'b1, 8'h80, 1'b1}, {1'b1, 8'h80, 1'b1},
            {1'b1, 8'h01, 1'b0}, {1'b1, 8'h01, 1'b0}, {1'b1, 8'h01, 1'b0},
            {1'b1, 8'h01, 1'b0}, {1'b1, 8'h01, 1'b0}, {1'b0, 8'h00, 1'b0},
            {1'b0, 8'h00, 1'b0}, {1'b0, 8'h00, 1'b0}, {1'b0, 8'h00, 1'b0},
            {1'b1, 8'h7F, 1'b1}
        };
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_byte_offered = 1'b0;
        i_data_byte    = '0;
        i_last_byte    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_SLOW_MODE;
        i_cfg_data     = '0;
        calm           = 1'b0;
        hold_req       = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one-tick bits, zero bits stay low
        program_timing(1'b0, 16'd0, 16'd1, 16'd1, 16'd50, 16'd120, 16'd250);
        foreach (directed[k]) begin
            send_item(directed[k][9], directed[k][8:1], directed[k][0]);
        end
        end_phase();

        // one bits held high past the period
        program_timing(1'b1, 16'd1, 16'd2, 16'd3, 16'd1, 16'd65535, 16'd4);
        send_random(90);
        end_phase();

        // zero period ends every bit after its first tick
        program_timing(1'b0, 16'd1, 16'd3, 16'd0, 16'd1, 16'd65535, 16'd4);
        send_random(60);
        end_phase();

        // long bit, then cut short by a smaller period
        program_timing(1'b1, 16'd1, 16'd3, 16'd0, 16'd65535, 16'd1, 16'd65535);
        send_random(40);
        end_phase();

        program_timing(1'b1, 16'd1, 16'd3, 16'd0, 16'd1, 16'd2, 16'd2);
        send_random(20);
        hold_req <= 1'b1;
        send_random(70);
        end_phase();

        for (int p = 0; p < 5; p++) begin
            calm <= (p == 1);
            program_timing(1'($urandom_range(1)),
                           16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                           16'($urandom_range(0, 8)), 16'($urandom_range(0, 6)),
                           16'($urandom_range(0, 6)), 16'($urandom_range(0, 8)));
            send_random(50);
            if (p == 2) begin
                settle();
            end
            send_random(50);
            end_phase();
        end
        calm <= 1'b0;

        program_timing(1'b0, 16'd65535, 16'd65535, 16'd65535, 16'd1, 16'd2, 16'd1);
        send_random(40);
        end_phase();

        program_timing(1'b0, RST_FAST_ZERO_HIGH, RST_FAST_ONE_HIGH, RST_FAST_PERIOD,
                       RST_SLOW_ZERO_HIGH, RST_SLOW_ONE_HIGH, RST_SLOW_PERIOD);
        send_random(40);
        end_phase();

        if (tracker.mismatches == 0 && tracker.expected_ticks.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== led_chain_pulse_encoder.f =====
rtl/lcpe_pkg.sv
rtl/led_chain_pulse_encoder.sv
sim/led_chain_pulse_encoder_test.sv
